/* design/msb_pkg.sv */
// Shared constants, types and helpers for the multi-stack shared buffer.
`timescale 1ns / 1ps

package msb_pkg;

    localparam int NUM_STACKS = 4;
    localparam int NUM_SLOTS  = 16;

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int SID_W   = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // slot pointer with a valid bit; a cleared valid bit is the null pointer
    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] idx;
    } ptr_t;

    // link memory contents after reset: slot i links to i+1, last is null
    function automatic ptr_t link_reset(input logic [SLOT_W-1:0] addr);
        logic [SLOT_W:0] nxt;
        ptr_t            p;
        nxt   = {1'b0, addr} + (SLOT_W + 1)'(1);
        p.vld = (nxt < (SLOT_W + 1)'(NUM_SLOTS));
        p.idx = nxt[SLOT_W-1:0];
        return p;
    endfunction

endpackage

/* design/multi_stack_shared_buffer.sv */
// Top level: several LIFO stacks threaded through one shared slot store.
`timescale 1ns / 1ps

// NUM_STACKS stacks share NUM_SLOTS slots. Each stack is a linked list through
// a link memory; unused slots form a free list. An item is push (operation 0)
// or pop (operation 1) on stack stack_id; every item yields exactly one result
// item with a status (0 ok, 1 push refused: no free slot or no such stack,
// 2 pop refused: stack empty or no such stack) and pop_value (the popped value
// on a successful pop, else zero). A refused item changes nothing.
// The accept cycle selects the slot from the free head or the stack head
// register and starts the synchronous read of the link and data memories;
// the execute state then links the slot, updates the heads, writes back and
// loads the output register. s_tready is high in the idle state only, so a
// new item is not taken until the one before has left the execute state.
// A result waiting in the output register does not block acceptance; the
// execute state stalls only until the output register is free. No clearing
// pass is needed after reset: per-entry flags give the reset link view.
module multi_stack_shared_buffer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] operation, [2:1] stack_id, [34:3] push_value, [39:35] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [33:2] pop_value, [39:34] zero
    output logic [39:0] m_tdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    localparam int SW = msb_pkg::SLOT_W;
    localparam int VW = msb_pkg::VALUE_W;

    // input fields
    logic                      in_op;
    logic [msb_pkg::SID_W-1:0] in_sid;
    logic [VW-1:0]             in_val;

    assign in_op  = s_tdata[0];
    assign in_sid = s_tdata[2:1];
    assign in_val = s_tdata[34:3];

    logic state_reg, state_next;

    // heads of the stacks and of the free list
    msb_pkg::ptr_t stack_head_reg [msb_pkg::NUM_STACKS];
    msb_pkg::ptr_t free_head_reg;

    // item in flight
    logic                        op_reg;
    logic [msb_pkg::SID_W-1:0]   sid_reg;
    logic [VW-1:0]               val_reg;
    logic [SW-1:0]               slot_reg;
    logic                        ok_reg;
    logic [msb_pkg::STAT_W-1:0]  status_reg;

    // output register
    logic                        m_tvalid_reg;
    logic [msb_pkg::STAT_W-1:0]  m_status_reg;
    logic [VW-1:0]               m_value_reg;

    // slot data memory, registered read
    logic [VW-1:0] slot_data [msb_pkg::NUM_SLOTS];
    logic [VW-1:0] data_rd_reg;

    msb_pkg::ptr_t link_rd;
    msb_pkg::ptr_t link_wr;

    logic          s_accept;
    logic          exec_done;
    logic          sid_ok;
    msb_pkg::ptr_t head_sel;
    logic          acc_ok;
    logic [SW-1:0] acc_slot;
    msb_pkg::ptr_t cur_head;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign exec_done = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    // pick the slot at accept time; stack numbers past the top are always empty
    always_comb begin
        sid_ok   = (32'(in_sid) < 32'(msb_pkg::NUM_STACKS));
        head_sel = stack_head_reg[in_sid];
        if (in_op == msb_pkg::OP_PUSH) begin
            acc_ok   = sid_ok && free_head_reg.vld;
            acc_slot = free_head_reg.idx;
        end else begin
            acc_ok   = sid_ok && head_sel.vld;
            acc_slot = head_sel.idx;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture the item
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= in_op;
            sid_reg  <= in_sid;
            val_reg  <= in_val;
            slot_reg <= acc_slot;
            ok_reg   <= acc_ok;
            if (acc_ok) begin
                status_reg <= msb_pkg::ST_OK;
            end else if (in_op == msb_pkg::OP_PUSH) begin
                status_reg <= msb_pkg::ST_FULL;
            end else begin
                status_reg <= msb_pkg::ST_EMPTY;
            end
        end
    end

    // data memory: read at accept, written by a successful push
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            data_rd_reg <= slot_data[acc_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_done && ok_reg && (op_reg == msb_pkg::OP_PUSH)) begin
            slot_data[slot_reg] <= val_reg;
        end
    end

    // push links the slot onto the stack; pop links it onto the free list
    assign cur_head = stack_head_reg[sid_reg];
    assign link_wr  = (op_reg == msb_pkg::OP_PUSH) ? cur_head : free_head_reg;

    msb_link_mem u_link (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (acc_slot),
        .rd_data (link_rd),
        .wr_en   (exec_done && ok_reg),
        .wr_addr (slot_reg),
        .wr_data (link_wr)
    );

    // head pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < msb_pkg::NUM_STACKS; i++) begin
                stack_head_reg[i] <= '0;
            end
            free_head_reg.vld <= 1'b1;
            free_head_reg.idx <= '0;
        end else if (exec_done && ok_reg) begin
            if (op_reg == msb_pkg::OP_PUSH) begin
                stack_head_reg[sid_reg].vld <= 1'b1;
                stack_head_reg[sid_reg].idx <= slot_reg;
                free_head_reg               <= link_rd;
            end else begin
                stack_head_reg[sid_reg] <= link_rd;
                free_head_reg.vld       <= 1'b1;
                free_head_reg.idx       <= slot_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (exec_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_done) begin
            m_status_reg <= status_reg;
            m_value_reg  <= (ok_reg && (op_reg == msb_pkg::OP_POP)) ? data_rd_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_value_reg, m_status_reg};

`ifndef SYNTHESIS
    // an accepted item always moves to the execute state
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == S_EXEC))
        else $error("accepted item did not enter execute");

    // a refused item leaves the free list alone
    a_refused_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_done && !ok_reg) |=> $stable(free_head_reg))
        else $error("refused item changed free head");

    // a successful pop makes the freed slot the free head
    a_pop_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_done && ok_reg && (op_reg == msb_pkg::OP_POP))
        |=> (free_head_reg.vld && (free_head_reg.idx == $past(slot_reg))))
        else $error("popped slot not returned to free list");

    // a pushed slot is no longer the free head
    a_push_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_done && ok_reg && (op_reg == msb_pkg::OP_PUSH))
        |=> !(free_head_reg.vld && (free_head_reg.idx == $past(slot_reg))))
        else $error("pushed slot still at free head");
`endif

endmodule

/* design/msb_link_mem.sv */
// Link memory: one next-slot pointer per slot, registered read, reset view per entry.
`timescale 1ns / 1ps

module msb_link_mem (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            rd_en,
    input  logic [msb_pkg::SLOT_W-1:0]      rd_addr,
    output msb_pkg::ptr_t                   rd_data,
    input  logic                            wr_en,
    input  logic [msb_pkg::SLOT_W-1:0]      wr_addr,
    input  msb_pkg::ptr_t                   wr_data
);

    msb_pkg::ptr_t                   mem [msb_pkg::NUM_SLOTS];
    logic [msb_pkg::NUM_SLOTS-1:0]   written_reg;
    msb_pkg::ptr_t                   rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // entries never written since reset read as their reset link
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else if (wr_en) begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= written_reg[rd_addr] ? mem[rd_addr]
                                                : msb_pkg::link_reset(rd_addr);
        end
    end

    assign rd_data = rd_data_reg;

endmodule
